[rtl/core/lpht_pkg.sv]
// Shared types and codes for the linear-probe hash table.
// Request/response payload structs, controller/datapath handshake structs.
// No dependencies.
package lpht_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned ValW     = 32;
  localparam int unsigned SizeW    = 5;
  localparam int unsigned SlotOutW = 4;
  localparam int unsigned DivSteps = 16;  // two dividend bits per step over 32 key bits
  localparam int unsigned DivCntW  = 4;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [KeyW-1:0]        key;
    logic signed [ValW-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [ValW-1:0] value_out;
    logic [SlotOutW-1:0]    slot_index;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic probe_init;
    logic probe_run;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic bad_req;
    logic hit;
    logic miss;
  } ctl_sts_t;

endpackage

[rtl/core/linear_probe_hash_table.sv]
// Top level of the linear-probe hash table: controller plus datapath.
// Depends on lpht_pkg, lpht_ctrl, lpht_dp (and lpht_ram through lpht_dp).
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+-------------------------------
//   request   | start & !busy              | req_i  (req_type, key, value_in)
//   result    | done_o, one cycle          | rsp_o  (status, value_out, slot_index)
//   config    | cfg_we_i                   | cfg_wdata_i (table_size)
//
// The modulo phase consumes two key bits per cycle; the probe phase then
// reads slots in turn from the hashed slot, comparing each one after its
// registered RAM read, until a hit or until every slot in use is tried;
// an unknown request type skips the probe and finishes after the modulo.
// The sequencer handles one request at a time; a new start is taken in the
// cycle done_o is high. Reset clears the valid bits and restores size 16.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i
);

  // The 5-bit size register cannot reach slots past 30.
  localparam int unsigned Depth = (SLOTS < 31) ? SLOTS : 31;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  lpht_dp #(.Depth(Depth)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

[rtl/core/lpht_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lpht_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/lpht_ctrl.sv]
// Sequencer for the hash table: modulo phase, probe phase, result.
// Depends on lpht_pkg.
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIV   = 3'b010,
    ST_PROBE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          if (sts_i.bad_req) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            cmd_o.probe_init = 1'b1;
            state_d          = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        cmd_o.probe_run = 1'b1;
        if (sts_i.hit || sts_i.miss) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  a_start_enters_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ST_DIV))
    else $error("accepted request did not enter modulo phase");
  a_finish_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !busy_o)
    else $error("still busy after finishing a request");
  a_probe_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_PROBE) |-> $past(sts_i.div_last))
    else $error("probe phase entered before modulo completed");
`endif

endmodule

[rtl/core/lpht_dp.sv]
// Datapath: size register, 2-bit-per-cycle modulo, probe pointer, valid bits,
// key/value RAMs and the result register. Depends on lpht_pkg and lpht_ram.
module lpht_dp
  import lpht_pkg::*;
#(
  parameter int unsigned Depth = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  input  req_t             req_i,
  input  ctl_cmd_t         cmd_i,
  output ctl_sts_t         sts_o,
  output logic             done_o,
  output rsp_t             rsp_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  function automatic logic [SizeW-1:0] mod_step(input logic [SizeW-1:0] r,
                                                input logic bit_in,
                                                input logic [SizeW-1:0] n);
    logic [SizeW:0] t;
    t = {r, bit_in};
    if (t >= {1'b0, n}) begin
      t = t - {1'b0, n};
    end
    return t[SizeW-1:0];
  endfunction

  logic [SizeW-1:0]   table_size_q;
  logic [1:0]         req_type_q;
  logic [KeyW-1:0]    key_q;
  logic [ValW-1:0]    val_q;
  logic [SizeW-1:0]   n_q, n_eff;
  logic [KeyW-1:0]    dividend_q;
  logic [SizeW-1:0]   rem_q, rem_mid, rem_d;
  logic [DivCntW-1:0] div_cnt_q;
  logic [IdxW-1:0]    pidx_q, cmp_idx_q;
  logic [SizeW-1:0]   issue_cnt_q;
  logic               cmp_v_q, cmp_last_q;
  logic [Depth-1:0]   valid_q;
  logic [KeyW-1:0]    rd_key;
  logic [ValW-1:0]    rd_val;
  logic               is_ins, bad_req, hit, miss, write_en;
  logic               done_q;
  rsp_t               rsp_q, rsp_d;

  // Size register; zero acts as one, anything above the storage acts as full depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= SizeW'(16);
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    n_eff = table_size_q;
    if (table_size_q == '0) begin
      n_eff = SizeW'(1);
    end else if (table_size_q > SizeW'(Depth)) begin
      n_eff = SizeW'(Depth);
    end
  end

  assign rem_mid = mod_step(rem_q, dividend_q[KeyW-1], n_q);
  assign rem_d   = mod_step(rem_mid, dividend_q[KeyW-2], n_q);

  assign is_ins  = (req_type_q == REQ_INSERT);
  assign bad_req = (req_type_q != REQ_INSERT) && (req_type_q != REQ_SEARCH) &&
                   (req_type_q != REQ_REMOVE);

  always_comb begin
    hit = 1'b0;
    if (cmp_v_q) begin
      if (is_ins) begin
        hit = !valid_q[cmp_idx_q];
      end else begin
        hit = valid_q[cmp_idx_q] && (rd_key == key_q);
      end
    end
  end
  assign miss = cmp_v_q && cmp_last_q && !hit;

  assign sts_o.div_last = (div_cnt_q == DivCntW'(DivSteps - 1));
  assign sts_o.bad_req  = bad_req;
  assign sts_o.hit      = hit;
  assign sts_o.miss     = miss;

  assign write_en = cmd_i.finish && !bad_req && hit && is_ins;

  // Request capture, modulo and probe pointers: payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req_i.req_type;
      key_q      <= req_i.key;
      val_q      <= req_i.value_in;
      n_q        <= n_eff;
      dividend_q <= req_i.key;
      rem_q      <= '0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      dividend_q <= {dividend_q[KeyW-3:0], 2'b00};
      rem_q      <= rem_d;
      div_cnt_q  <= div_cnt_q + DivCntW'(1);
    end
    if (cmd_i.probe_init) begin
      pidx_q      <= rem_d[IdxW-1:0];
      issue_cnt_q <= '0;
    end else if (cmd_i.probe_run && (issue_cnt_q != n_q)) begin
      // Wrap from the last slot in use back to slot zero.
      if (SizeW'(pidx_q) == n_q - SizeW'(1)) begin
        pidx_q <= '0;
      end else begin
        pidx_q <= pidx_q + IdxW'(1);
      end
      issue_cnt_q <= issue_cnt_q + SizeW'(1);
      cmp_idx_q   <= pidx_q;
      cmp_last_q  <= (issue_cnt_q == n_q - SizeW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_v_q <= 1'b0;
    end else if (cmd_i.load || cmd_i.probe_init) begin
      cmp_v_q <= 1'b0;
    end else if (cmd_i.probe_run) begin
      cmp_v_q <= (issue_cnt_q != n_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.finish && !bad_req && hit) begin
      unique case (req_type_q)
        REQ_INSERT: valid_q[cmp_idx_q] <= 1'b1;
        REQ_REMOVE: valid_q[cmp_idx_q] <= 1'b0;
        default:    valid_q <= valid_q;
      endcase
    end
  end

  lpht_ram #(.Width(KeyW), .Depth(Depth)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (write_en),
    .waddr_i (cmp_idx_q),
    .wdata_i (key_q),
    .raddr_i (pidx_q),
    .rdata_o (rd_key)
  );

  lpht_ram #(.Width(ValW), .Depth(Depth)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (write_en),
    .waddr_i (cmp_idx_q),
    .wdata_i (val_q),
    .raddr_i (pidx_q),
    .rdata_o (rd_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_comb begin
    rsp_d = '0;
    if (bad_req) begin
      rsp_d.status = STAT_NOT_FOUND;
    end else if (hit) begin
      rsp_d.status     = STAT_OK;
      rsp_d.slot_index = SlotOutW'(cmp_idx_q);
      if (req_type_q == REQ_SEARCH) begin
        rsp_d.value_out = rd_val;
      end
    end else if (is_ins) begin
      rsp_d.status = STAT_FULL;
    end else begin
      rsp_d.status = STAT_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_insert_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && write_en) |=> valid_q[$past(cmp_idx_q)])
    else $error("insert did not mark its slot valid");
  a_error_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.status != STAT_OK) |-> (rsp_q.slot_index == '0 && rsp_q.value_out == '0))
    else $error("error result carries nonzero fields");
  a_finish_strobes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> done_q)
    else $error("finished request produced no result strobe");
`endif

endmodule
